// ----- hdl/dual_servo_pwm_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Dual servo PWM generator - assertion macros
// Shared helpers for the concurrent checks on the generator's ports.
// ----------------------------------------------------------------------------
`ifndef DUAL_SERVO_PWM_GENERATOR_DEFINES_SVH
`define DUAL_SERVO_PWM_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DSPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DSPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dspg_pkg.sv -----
// ----------------------------------------------------------------------------
// dspg_pkg
// Types and constants shared by the dual servo PWM generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

    localparam int unsigned PERIOD_TICKS_DEF = 200;

    localparam int unsigned CNT_W  = 8;
    localparam int unsigned HZ_W   = 17;
    localparam int unsigned PROD_W = 25;
    localparam int unsigned ANG_W  = 8;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [HZ_W-1:0]   HZ_RESET     = HZ_W'(10000);
    localparam logic [ANG_W-1:0]  ANGLE_MAX    = ANG_W'(180);
    localparam logic [ANG_W-1:0]  ANGLE_OFFSET = ANG_W'(60);
    // one tick of pulse width per 100000 units of (angle + 60) * tick_hz
    localparam logic [PROD_W-1:0] TICK_STEP    = PROD_W'(100000);
    // product that yields the reset width of six ticks
    localparam logic [PROD_W-1:0] PROD_RESET   = PROD_W'(600000);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ENABLE = 2'd1;
    localparam logic [1:0] OP_ANGLE  = 2'd2;

    localparam logic [1:0] CH_ONE = 2'd1;
    localparam logic [1:0] CH_TWO = 2'd2;

    localparam logic [ADDR_W-3:0] REG_TICK_HZ = '0;

    typedef struct packed {
        logic tick;     // tick beat in the work stage
        logic at_zero;  // tick count is zero
        logic en_we;    // enable write to this channel
        logic en_val;
        logic wid_we;   // angle write to this channel
    } t_chan_ctl;

endpackage

// ----- hdl/dspg_channel.sv -----
// ----------------------------------------------------------------------------
// dspg_channel
// One servo channel: enable flag, stored pulse product and pin level.
// ----------------------------------------------------------------------------
module dspg_channel
    import dspg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chan_ctl         i_ctl,
    input  logic [PROD_W-1:0] i_count_base,
    input  logic [PROD_W-1:0] i_product,
    output logic              o_level
);

    logic              r_enabled;
    logic              r_level;
    logic [PROD_W-1:0] r_product;
    logic              n_level;
    logic              w_hit;

    // width == count  <=>  count*STEP <= product < (count+1)*STEP
    // count never reaches 255, so the 255 saturation never matches
    assign w_hit = (r_product >= i_count_base) && (r_product < (i_count_base + TICK_STEP));

    always_comb begin
        n_level = r_level;
        if (i_ctl.tick) begin
            if (i_ctl.at_zero) begin
                if (r_enabled) n_level = 1'b1;
            end else if (r_level && w_hit) begin
                n_level = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_level   <= 1'b0;
            r_product <= PROD_RESET;
        end else begin
            r_level <= n_level;
            if (i_ctl.en_we)  r_enabled <= i_ctl.en_val;
            if (i_ctl.wid_we) r_product <= i_product;
        end
    end

    assign o_level = r_level;

endmodule

// ----- hdl/dual_servo_pwm_generator.sv -----
// ----------------------------------------------------------------------------
// dual_servo_pwm_generator
// Two-channel servo pulse generator driven by tick / enable / angle beats.
//
//   channel   handshake            payload
//   input     i_valid / o_ready    i_op, i_channel, i_enable, i_angle_degrees
//   output    o_valid / i_ready    o_pin_one, o_pin_two, o_status
//   config    APB psel / penable   paddr, pwdata, prdata (tick_hz at 0x0)
//
// One beat per cycle sustained unless the output stalls. Path: input register,
// then state update plus result register. The angle multiply sits in the
// second stage. Reset is synchronous and clears all control state. A
// stalled output holds its beat while one more input beat is buffered.
// ----------------------------------------------------------------------------
module dual_servo_pwm_generator
    import dspg_pkg::*;
#(
    parameter int unsigned PERIOD_TICKS = PERIOD_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic [1:0]        i_channel,
    input  logic              i_enable,
    input  logic [ANG_W-1:0]  i_angle_degrees,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_pin_one,
    output logic              o_pin_two,
    output logic              o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PERIOD_TICKS - 1);

    logic [HZ_W-1:0]   r_tick_hz;
    logic              r_s1_valid;
    logic [1:0]        r_op;
    logic [1:0]        r_channel;
    logic              r_enable;
    logic [ANG_W-1:0]  r_angle;
    logic              r_out_valid;
    logic              r_status;
    logic [CNT_W-1:0]  r_count;
    logic [PROD_W-1:0] r_count_base;

    logic              w_go;
    logic              w_tick;
    logic              w_ch_bad;
    logic              n_status;
    logic [ANG_W-1:0]  w_cdeg;
    logic [PROD_W-1:0] w_product;
    t_chan_ctl         w_ctl_one;
    t_chan_ctl         w_ctl_two;

    // ---- config port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_TICK_HZ) ? DATA_W'(r_tick_hz) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_hz <= HZ_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_TICK_HZ) begin
            r_tick_hz <= pwdata[HZ_W-1:0];
        end
    end

    // ---- pipeline control
    assign w_go    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_s1_valid <= i_valid;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op      <= i_op;
            r_channel <= i_channel;
            r_enable  <= i_enable;
            r_angle   <= i_angle_degrees;
        end
    end

    // ---- work stage
    assign w_tick   = w_go && (r_op == OP_TICK);
    assign w_ch_bad = (r_channel != CH_ONE) && (r_channel != CH_TWO);
    assign n_status = ((r_op == OP_ENABLE) || (r_op == OP_ANGLE)) && w_ch_bad;

    assign w_cdeg    = ((r_angle > ANGLE_MAX) ? ANGLE_MAX : r_angle) + ANGLE_OFFSET;
    assign w_product = PROD_W'(w_cdeg) * PROD_W'(r_tick_hz);

    always_comb begin
        w_ctl_one         = '0;
        w_ctl_one.tick    = w_tick;
        w_ctl_one.at_zero = (r_count == '0);
        w_ctl_one.en_val  = r_enable;
        w_ctl_two         = w_ctl_one;
        w_ctl_one.en_we   = w_go && (r_op == OP_ENABLE) && (r_channel == CH_ONE);
        w_ctl_two.en_we   = w_go && (r_op == OP_ENABLE) && (r_channel == CH_TWO);
        w_ctl_one.wid_we  = w_go && (r_op == OP_ANGLE) && (r_channel == CH_ONE);
        w_ctl_two.wid_we  = w_go && (r_op == OP_ANGLE) && (r_channel == CH_TWO);
    end

    // count and count*TICK_STEP advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_count_base <= '0;
        end else if (w_tick) begin
            if (r_count == LAST_COUNT) begin
                r_count      <= '0;
                r_count_base <= '0;
            end else begin
                r_count      <= r_count + 1'b1;
                r_count_base <= r_count_base + TICK_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) r_status <= n_status;
    end

    // pin levels change only when a result loads, so they double as the
    // output register for the pins
    dspg_channel u_chan_one (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_one),
        .i_count_base (r_count_base),
        .i_product    (w_product),
        .o_level      (o_pin_one)
    );

    dspg_channel u_chan_two (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl_two),
        .i_count_base (r_count_base),
        .i_product    (w_product),
        .o_level      (o_pin_two)
    );

    assign o_valid  = r_out_valid;
    assign o_status = r_status;

endmodule

// ----- hdl/dspg_checker.sv -----
// ----------------------------------------------------------------------------
// dspg_checker
// Port-level checks for the dual servo PWM generator, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_servo_pwm_generator_defines.svh"

module dspg_checker
    import dspg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_pin_one,
    input logic              o_pin_two,
    input logic              o_status,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata
);

    logic            w_stall;
    logic [2:0]      w_beat;
    logic            w_cfg_sel;
    logic            w_cfg_wr;
    logic            w_cfg_ok;
    logic [HZ_W-1:0] r_last_hz;

    assign w_stall   = o_valid && !i_ready;
    assign w_beat    = {o_pin_one, o_pin_two, o_status};
    assign w_cfg_sel = (paddr[ADDR_W-1:2] == REG_TICK_HZ);
    assign w_cfg_wr  = psel && penable && pwrite && w_cfg_sel;
    assign w_cfg_ok  = !w_cfg_sel || (prdata[HZ_W-1:0] == r_last_hz);

    // value on the write bus in the previous cycle
    always_ff @(posedge i_clk) begin
        r_last_hz <= pwdata[HZ_W-1:0];
    end

    // a stalled result beat holds
    `DSPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_valid && $stable(w_beat), "beat not held")

    // with the result slot empty the input side never stalls
    `DSPG_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready, "stall while empty")

    // a written tick rate reads back on the next cycle
    `DSPG_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, w_cfg_wr, w_cfg_ok, "tick_hz readback mismatch")

endmodule

bind dual_servo_pwm_generator dspg_checker u_dspg_checker (.*);
